>>> hdl/htms_pkg.sv
// Shared types, codes and reset values for the timed mode sequencer.
// Used by htms_csr, htms_decide and hvac_timed_mode_sequencer; depends on nothing.
`default_nettype none

package htms_pkg;

   localparam int unsigned TimeWidth = 16;
   localparam int unsigned ModeWidth = 3;
   localparam int unsigned CsrIndexWidth = 3;

   // Default inter-function gaps, in timer counts.
   localparam logic [TimeWidth-1:0] CoolInstantGapDefault = 16'd300;
   localparam logic [TimeWidth-1:0] HeatInstantGapDefault = 16'd300;
   localparam logic [TimeWidth-1:0] CoolToCoolGapDefault  = 16'd300;
   localparam logic [TimeWidth-1:0] HeatToCoolGapDefault  = 16'd300;
   localparam logic [TimeWidth-1:0] HeatToHeatGapDefault  = 16'd300;
   localparam logic [TimeWidth-1:0] CoolToHeatGapDefault  = 16'd300;

   typedef enum logic [ModeWidth-1:0] {
      MODE_OFF     = 3'd0,
      MODE_FAN     = 3'd1,
      MODE_COOL    = 3'd2,
      MODE_HEAT    = 3'd3,
      MODE_COOLFAN = 3'd4,
      MODE_HEATFAN = 3'd5,
      MODE_INITIAL = 3'd6,
      MODE_ILLEGAL = 3'd7
   } mode_type;

   typedef enum logic [1:0] {
      LF_UNKNOWN = 2'd0,
      LF_COOL    = 2'd1,
      LF_HEAT    = 2'd2
   } last_func_type;

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_FAN_MIN_OFF     = 3'd0,
      CSR_FAN_MIN_ON      = 3'd1,
      CSR_COOL_MIN_ON     = 3'd2,
      CSR_HEAT_MIN_ON     = 3'd3,
      CSR_FAN_AFTER_COOL  = 3'd4,
      CSR_FAN_AFTER_HEAT  = 3'd5,
      CSR_FAN_BEFORE_COOL = 3'd6,
      CSR_FAN_BEFORE_HEAT = 3'd7
   } csr_index_type;

   typedef enum logic [3:0] {
      RULE_NONE,
      RULE_OFF_FAN,
      RULE_FAN_OFF,
      RULE_FAN_COOL,
      RULE_FAN_HEAT,
      RULE_COOL_STOP,
      RULE_COOLFAN_OFF,
      RULE_COOLFAN_FAN,
      RULE_HEAT_STOP,
      RULE_HEATFAN_OFF,
      RULE_HEATFAN_FAN
   } rule_type;

   // Register reset values.
   localparam logic [TimeWidth-1:0] FanMinOffReset     = 16'd60;
   localparam logic [TimeWidth-1:0] FanMinOnReset      = 16'd60;
   localparam logic [TimeWidth-1:0] CoolMinOnReset     = 16'd180;
   localparam logic [TimeWidth-1:0] HeatMinOnReset     = 16'd180;
   localparam logic [TimeWidth-1:0] FanAfterCoolReset  = 16'd60;
   localparam logic [TimeWidth-1:0] FanAfterHeatReset  = 16'd60;
   localparam logic [TimeWidth-1:0] FanBeforeCoolReset = 16'd30;
   localparam logic [TimeWidth-1:0] FanBeforeHeatReset = 16'd30;

   typedef struct packed {
      logic [TimeWidth-1:0] fan_min_off;
      logic [TimeWidth-1:0] fan_min_on;
      logic [TimeWidth-1:0] cool_min_on;
      logic [TimeWidth-1:0] heat_min_on;
      logic [TimeWidth-1:0] fan_after_cool;
      logic [TimeWidth-1:0] fan_after_heat;
      logic [TimeWidth-1:0] fan_before_cool;
      logic [TimeWidth-1:0] fan_before_heat;
   } cfg_type;

   typedef struct packed {
      mode_type             present_state;
      mode_type             wanted_state;
      logic [TimeWidth-1:0] fan_on_time;
      logic [TimeWidth-1:0] fan_off_time;
      logic [TimeWidth-1:0] cool_on_time;
      logic [TimeWidth-1:0] cool_off_time;
      logic [TimeWidth-1:0] heat_on_time;
      logic [TimeWidth-1:0] heat_off_time;
   } req_type;

   typedef struct packed {
      mode_type      next_state;
      logic          lf_write;
      last_func_type lf_value;
   } decision_type;

   // The transition table: which guarded rule serves a (present, wanted) pair.
   function automatic rule_type rule_of(input mode_type present, input mode_type wanted);
      rule_type rule;
      rule = RULE_NONE;
      case (present)
         MODE_OFF: begin
            if (wanted inside {MODE_FAN, MODE_COOL, MODE_HEAT}) rule = RULE_OFF_FAN;
         end
         MODE_FAN: begin
            case (wanted)
               MODE_OFF:  rule = RULE_FAN_OFF;
               MODE_COOL: rule = RULE_FAN_COOL;
               MODE_HEAT: rule = RULE_FAN_HEAT;
               default:   rule = RULE_NONE;
            endcase
         end
         MODE_COOL: begin
            if (wanted inside {MODE_OFF, MODE_FAN, MODE_HEAT, MODE_COOLFAN}) begin
               rule = RULE_COOL_STOP;
            end
         end
         MODE_HEAT: begin
            if (wanted inside {MODE_OFF, MODE_FAN, MODE_COOL, MODE_HEATFAN}) begin
               rule = RULE_HEAT_STOP;
            end
         end
         MODE_COOLFAN: begin
            if (wanted == MODE_OFF) rule = RULE_COOLFAN_OFF;
            else if (wanted inside {MODE_FAN, MODE_COOL, MODE_HEAT}) rule = RULE_COOLFAN_FAN;
         end
         MODE_HEATFAN: begin
            if (wanted == MODE_OFF) rule = RULE_HEATFAN_OFF;
            else if (wanted inside {MODE_FAN, MODE_COOL, MODE_HEAT}) rule = RULE_HEATFAN_FAN;
         end
         default: rule = RULE_NONE;
      endcase
      return rule;
   endfunction

endpackage

`default_nettype wire

>>> hdl/htms_csr.sv
// Configuration register file: eight 16-bit timing thresholds, write only.
// Depends on htms_pkg.
`default_nettype none

module htms_csr (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_write,
   input  wire logic [htms_pkg::CsrIndexWidth-1:0]  csr_index,
   input  wire logic [htms_pkg::TimeWidth-1:0]      csr_data,
   output htms_pkg::cfg_type                        cfg
);

   htms_pkg::cfg_type cfg_ff;
   htms_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (htms_pkg::csr_index_type'(csr_index))
            htms_pkg::CSR_FAN_MIN_OFF:     cfg_in.fan_min_off     = csr_data;
            htms_pkg::CSR_FAN_MIN_ON:      cfg_in.fan_min_on      = csr_data;
            htms_pkg::CSR_COOL_MIN_ON:     cfg_in.cool_min_on     = csr_data;
            htms_pkg::CSR_HEAT_MIN_ON:     cfg_in.heat_min_on     = csr_data;
            htms_pkg::CSR_FAN_AFTER_COOL:  cfg_in.fan_after_cool  = csr_data;
            htms_pkg::CSR_FAN_AFTER_HEAT:  cfg_in.fan_after_heat  = csr_data;
            htms_pkg::CSR_FAN_BEFORE_COOL: cfg_in.fan_before_cool = csr_data;
            htms_pkg::CSR_FAN_BEFORE_HEAT: cfg_in.fan_before_heat = csr_data;
            default:                       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.fan_min_off     <= htms_pkg::FanMinOffReset;
         cfg_ff.fan_min_on      <= htms_pkg::FanMinOnReset;
         cfg_ff.cool_min_on     <= htms_pkg::CoolMinOnReset;
         cfg_ff.heat_min_on     <= htms_pkg::HeatMinOnReset;
         cfg_ff.fan_after_cool  <= htms_pkg::FanAfterCoolReset;
         cfg_ff.fan_after_heat  <= htms_pkg::FanAfterHeatReset;
         cfg_ff.fan_before_cool <= htms_pkg::FanBeforeCoolReset;
         cfg_ff.fan_before_heat <= htms_pkg::FanBeforeHeatReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

>>> hdl/htms_decide.sv
// Guarded transition rules: picks the rule for a request and evaluates its guard.
// Depends on htms_pkg; purely combinational.
`default_nettype none

module htms_decide #(
   parameter logic [htms_pkg::TimeWidth-1:0] COOL_INSTANT_GAP = htms_pkg::CoolInstantGapDefault,
   parameter logic [htms_pkg::TimeWidth-1:0] HEAT_INSTANT_GAP = htms_pkg::HeatInstantGapDefault,
   parameter logic [htms_pkg::TimeWidth-1:0] COOL_TO_COOL_GAP = htms_pkg::CoolToCoolGapDefault,
   parameter logic [htms_pkg::TimeWidth-1:0] HEAT_TO_COOL_GAP = htms_pkg::HeatToCoolGapDefault,
   parameter logic [htms_pkg::TimeWidth-1:0] HEAT_TO_HEAT_GAP = htms_pkg::HeatToHeatGapDefault,
   parameter logic [htms_pkg::TimeWidth-1:0] COOL_TO_HEAT_GAP = htms_pkg::CoolToHeatGapDefault
) (
   input  wire htms_pkg::req_type        req,
   input  wire htms_pkg::cfg_type        cfg,
   input  wire htms_pkg::last_func_type  last_function,
   output htms_pkg::decision_type        decision
);

   htms_pkg::rule_type rule;
   logic               known;
   logic               cool_pre_block;
   logic               cool_gap_block;
   logic               heat_pre_block;
   logic               heat_gap_block;

   assign rule  = htms_pkg::rule_of(req.present_state, req.wanted_state);
   assign known = (last_function != htms_pkg::LF_UNKNOWN);

   // A start soon after either function stopped needs the fan pre-run first;
   // once a function is remembered the full gaps apply as well.
   assign cool_pre_block = ((req.cool_off_time < COOL_INSTANT_GAP) ||
                            (req.heat_off_time < COOL_INSTANT_GAP)) &&
                           (req.fan_on_time < cfg.fan_before_cool);
   assign cool_gap_block = known && ((req.cool_off_time < COOL_TO_COOL_GAP) ||
                                     (req.heat_off_time < HEAT_TO_COOL_GAP));
   assign heat_pre_block = ((req.heat_off_time < HEAT_INSTANT_GAP) ||
                            (req.cool_off_time < HEAT_INSTANT_GAP)) &&
                           (req.fan_on_time < cfg.fan_before_heat);
   assign heat_gap_block = known && ((req.heat_off_time < HEAT_TO_HEAT_GAP) ||
                                     (req.cool_off_time < COOL_TO_HEAT_GAP));

   always_comb begin
      decision.next_state = htms_pkg::MODE_ILLEGAL;
      decision.lf_write   = 1'b0;
      decision.lf_value   = htms_pkg::LF_UNKNOWN;
      case (rule)
         htms_pkg::RULE_OFF_FAN: begin
            decision.next_state = (req.fan_off_time < cfg.fan_min_off) ?
                                  htms_pkg::MODE_OFF : htms_pkg::MODE_FAN;
         end
         htms_pkg::RULE_FAN_OFF: begin
            decision.next_state = (req.fan_on_time < cfg.fan_min_on) ?
                                  htms_pkg::MODE_FAN : htms_pkg::MODE_OFF;
         end
         htms_pkg::RULE_FAN_COOL: begin
            if (cool_pre_block || cool_gap_block) begin
               decision.next_state = htms_pkg::MODE_FAN;
            end else begin
               decision.next_state = htms_pkg::MODE_COOL;
               decision.lf_write   = 1'b1;
               decision.lf_value   = htms_pkg::LF_COOL;
            end
         end
         htms_pkg::RULE_FAN_HEAT: begin
            if (heat_pre_block || heat_gap_block) begin
               decision.next_state = htms_pkg::MODE_FAN;
            end else begin
               decision.next_state = htms_pkg::MODE_HEAT;
               decision.lf_write   = 1'b1;
               decision.lf_value   = htms_pkg::LF_HEAT;
            end
         end
         htms_pkg::RULE_COOL_STOP: begin
            if (req.cool_on_time < cfg.cool_min_on) begin
               decision.next_state = htms_pkg::MODE_COOL;
            end else begin
               decision.next_state = htms_pkg::MODE_COOLFAN;
               decision.lf_write   = 1'b1;
               decision.lf_value   = htms_pkg::LF_COOL;
            end
         end
         htms_pkg::RULE_COOLFAN_OFF: begin
            decision.next_state = (req.cool_off_time < cfg.fan_after_cool) ?
                                  htms_pkg::MODE_COOLFAN : htms_pkg::MODE_OFF;
         end
         htms_pkg::RULE_COOLFAN_FAN: begin
            decision.next_state = (req.cool_off_time < cfg.fan_after_cool) ?
                                  htms_pkg::MODE_COOLFAN : htms_pkg::MODE_FAN;
         end
         htms_pkg::RULE_HEAT_STOP: begin
            if (req.heat_on_time < cfg.heat_min_on) begin
               decision.next_state = htms_pkg::MODE_HEAT;
            end else begin
               decision.next_state = htms_pkg::MODE_HEATFAN;
               decision.lf_write   = 1'b1;
               decision.lf_value   = htms_pkg::LF_HEAT;
            end
         end
         htms_pkg::RULE_HEATFAN_OFF: begin
            decision.next_state = (req.heat_off_time < cfg.fan_after_heat) ?
                                  htms_pkg::MODE_HEATFAN : htms_pkg::MODE_OFF;
         end
         htms_pkg::RULE_HEATFAN_FAN: begin
            decision.next_state = (req.heat_off_time < cfg.fan_after_heat) ?
                                  htms_pkg::MODE_HEATFAN : htms_pkg::MODE_FAN;
         end
         default: begin
            decision.next_state = htms_pkg::MODE_ILLEGAL;
         end
      endcase
   end

endmodule

`default_nettype wire

>>> hdl/hvac_timed_mode_sequencer.sv
// Top level of the timed mode sequencer: request register, rule evaluation,
// result register and the remembered conditioning function.
// Depends on htms_pkg, htms_csr and htms_decide.
//
// Usage. Each request beat on the req_ channel carries the present mode, the
// wanted mode and six elapsed-time counters. For every request exactly one
// response beat leaves on the rsp_ channel with the next mode, or the illegal
// code for a mode pair that has no transition rule.
// A beat is taken at a rising edge where valid is high and stall is low.
// A taken request is held and evaluated in the request register; its next
// mode is loaded into the response register, with rsp_valid, as it advances.
// Throughput: one request per cycle while rsp_stall is low, set by the single
// register-to-register pass through the rule table and the threshold
// comparators. When the receiver stalls, the response register holds its
// beat; the request register then holds one more request and req_stall
// rises only once both are full, so the two sides stay decoupled.
// The thresholds are written through the csr_ port (index 0 to 7, see the
// register list in the package); the user must write them only while no
// request is in flight, as the block itself does not enforce it.
// Reset clears both stage valid flags, returns the thresholds to their default
// values and forgets the last conditioning function, which disables the
// inter-function gap checks until cooling or heating has run once.
`default_nettype none

module hvac_timed_mode_sequencer #(
   parameter logic [htms_pkg::TimeWidth-1:0] COOL_INSTANT_GAP = htms_pkg::CoolInstantGapDefault,
   parameter logic [htms_pkg::TimeWidth-1:0] HEAT_INSTANT_GAP = htms_pkg::HeatInstantGapDefault,
   parameter logic [htms_pkg::TimeWidth-1:0] COOL_TO_COOL_GAP = htms_pkg::CoolToCoolGapDefault,
   parameter logic [htms_pkg::TimeWidth-1:0] HEAT_TO_COOL_GAP = htms_pkg::HeatToCoolGapDefault,
   parameter logic [htms_pkg::TimeWidth-1:0] HEAT_TO_HEAT_GAP = htms_pkg::HeatToHeatGapDefault,
   parameter logic [htms_pkg::TimeWidth-1:0] COOL_TO_HEAT_GAP = htms_pkg::CoolToHeatGapDefault
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // Request channel.
   input  wire logic                                req_valid,
   output      logic                                req_stall,
   input  wire logic [htms_pkg::ModeWidth-1:0]      req_present_state,
   input  wire logic [htms_pkg::ModeWidth-1:0]      req_wanted_state,
   input  wire logic [htms_pkg::TimeWidth-1:0]      req_fan_on_time,
   input  wire logic [htms_pkg::TimeWidth-1:0]      req_fan_off_time,
   input  wire logic [htms_pkg::TimeWidth-1:0]      req_cool_on_time,
   input  wire logic [htms_pkg::TimeWidth-1:0]      req_cool_off_time,
   input  wire logic [htms_pkg::TimeWidth-1:0]      req_heat_on_time,
   input  wire logic [htms_pkg::TimeWidth-1:0]      req_heat_off_time,
   // Response channel.
   output      logic                                rsp_valid,
   input  wire logic                                rsp_stall,
   output      logic [htms_pkg::ModeWidth-1:0]      rsp_next_state,
   // Configuration write port.
   input  wire logic                                csr_write,
   input  wire logic [htms_pkg::CsrIndexWidth-1:0]  csr_index,
   input  wire logic [htms_pkg::TimeWidth-1:0]      csr_data
);

   htms_pkg::cfg_type       cfg;
   htms_pkg::decision_type  decision;

   // Request register.
   logic                    req_valid_ff;
   logic                    req_valid_in;
   htms_pkg::req_type       req_ff;

   // Response register.
   logic                    rsp_valid_ff;
   logic                    rsp_valid_in;
   htms_pkg::mode_type      rsp_state_ff;

   // Last conditioning function.
   htms_pkg::last_func_type last_function_ff;
   htms_pkg::last_func_type last_function_in;

   logic                    take_req;
   logic                    advance;

   htms_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   htms_decide #(
      .COOL_INSTANT_GAP (COOL_INSTANT_GAP),
      .HEAT_INSTANT_GAP (HEAT_INSTANT_GAP),
      .COOL_TO_COOL_GAP (COOL_TO_COOL_GAP),
      .HEAT_TO_COOL_GAP (HEAT_TO_COOL_GAP),
      .HEAT_TO_HEAT_GAP (HEAT_TO_HEAT_GAP),
      .COOL_TO_HEAT_GAP (COOL_TO_HEAT_GAP)
   ) u_decide (
      .req           (req_ff),
      .cfg           (cfg),
      .last_function (last_function_ff),
      .decision      (decision)
   );

   // The held request moves on whenever the response register is empty or
   // its beat is being taken in this cycle.
   assign advance   = req_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = req_valid_ff && !advance;
   assign take_req  = req_valid && !req_stall;

   always_comb begin
      req_valid_in = req_valid_ff;
      if (take_req) begin
         req_valid_in = 1'b1;
      end else if (advance) begin
         req_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // The function memory is updated in request order, as each request is
   // evaluated, so the next request always sees its predecessor's effect.
   always_comb begin
      last_function_in = last_function_ff;
      if (advance && decision.lf_write) begin
         last_function_in = decision.lf_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff     <= 1'b0;
         rsp_valid_ff     <= 1'b0;
         last_function_ff <= htms_pkg::LF_UNKNOWN;
      end else begin
         req_valid_ff     <= req_valid_in;
         rsp_valid_ff     <= rsp_valid_in;
         last_function_ff <= last_function_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take_req) begin
         req_ff.present_state <= htms_pkg::mode_type'(req_present_state);
         req_ff.wanted_state  <= htms_pkg::mode_type'(req_wanted_state);
         req_ff.fan_on_time   <= req_fan_on_time;
         req_ff.fan_off_time  <= req_fan_off_time;
         req_ff.cool_on_time  <= req_cool_on_time;
         req_ff.cool_off_time <= req_cool_off_time;
         req_ff.heat_on_time  <= req_heat_on_time;
         req_ff.heat_off_time <= req_heat_off_time;
      end
      if (advance) begin
         rsp_state_ff <= decision.next_state;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_next_state = rsp_state_ff;

   // The remembered function changes only when a request is evaluated.
   a_lf_only_on_advance: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(last_function_ff))
      else $error("last function changed without an evaluated request");

   // An unlisted mode pair never touches the remembered function.
   a_illegal_keeps_lf: assert property (@(posedge clock) disable iff (reset)
      advance && decision.next_state == htms_pkg::MODE_ILLEGAL |=> $stable(last_function_ff))
      else $error("illegal request altered the last function");

   // A granted start of cooling from fan leaves cooling remembered.
   a_cool_start_sets_lf: assert property (@(posedge clock) disable iff (reset)
      advance && req_ff.present_state == htms_pkg::MODE_FAN &&
      decision.next_state == htms_pkg::MODE_COOL
      |=> last_function_ff == htms_pkg::LF_COOL)
      else $error("cooling start did not record cooling");

   // Requests are refused only while the request register is occupied.
   a_stall_needs_held_req: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> req_valid_ff && rsp_valid_ff && rsp_stall)
      else $error("request stalled with free pipeline space");

   // A response held under stall keeps its mode code.
   a_rsp_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall |=> rsp_valid_ff && $stable(rsp_state_ff))
      else $error("stalled response lost or changed");

endmodule

`default_nettype wire

>>> tb/tb.sv
// Self-checking testbench for hvac_timed_mode_sequencer: directed and random mode requests,
// threshold rewrites and response back-pressure, checked against an in-bench predictor.
// Depends on htms_pkg and the hvac_timed_mode_sequencer RTL only.
`default_nettype none

module tb;
   timeunit 1ns;
   timeprecision 1ps;

   typedef logic [htms_pkg::TimeWidth-1:0] time_type;

   // Clock, reset and every block input start at a known value.
   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic                                req_valid = 1'b0;
   logic                                req_stall;
   logic [htms_pkg::ModeWidth-1:0]      req_present_state = '0;
   logic [htms_pkg::ModeWidth-1:0]      req_wanted_state = '0;
   time_type                            req_fan_on_time = '0;
   time_type                            req_fan_off_time = '0;
   time_type                            req_cool_on_time = '0;
   time_type                            req_cool_off_time = '0;
   time_type                            req_heat_on_time = '0;
   time_type                            req_heat_off_time = '0;
   logic                                rsp_valid;
   logic                                rsp_stall = 1'b0;
   logic [htms_pkg::ModeWidth-1:0]      rsp_next_state;
   logic                                csr_write = 1'b0;
   logic [htms_pkg::CsrIndexWidth-1:0]  csr_index = '0;
   time_type                            csr_data = '0;

   // Predictor state: our own copy of the thresholds and of the remembered function.
   htms_pkg::cfg_type model_cfg = '{htms_pkg::FanMinOffReset, htms_pkg::FanMinOnReset,
                                    htms_pkg::CoolMinOnReset, htms_pkg::HeatMinOnReset,
                                    htms_pkg::FanAfterCoolReset, htms_pkg::FanAfterHeatReset,
                                    htms_pkg::FanBeforeCoolReset,
                                    htms_pkg::FanBeforeHeatReset};
   htms_pkg::last_func_type model_last_func = htms_pkg::LF_UNKNOWN;
   htms_pkg::mode_type      last_prediction = htms_pkg::MODE_OFF;

   // Next modes still owed by the block, oldest first.
   htms_pkg::mode_type pending_modes[$];
   htms_pkg::mode_type owed_mode;

   int failures = 0;

   // Idling controls: percentage chance that a beat is preceded by a gap or stall,
   // plus a long receiver hold-off used to fill the block up.
   int req_gap_pct = 0;
   int rsp_gap_pct = 0;
   int hold_cycles = 0;
   int stall_left = 0;
   bit beat_taken = 1'b0;

   hvac_timed_mode_sequencer DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_present_state (req_present_state),
      .req_wanted_state  (req_wanted_state),
      .req_fan_on_time   (req_fan_on_time),
      .req_fan_off_time  (req_fan_off_time),
      .req_cool_on_time  (req_cool_on_time),
      .req_cool_off_time (req_cool_off_time),
      .req_heat_on_time  (req_heat_on_time),
      .req_heat_off_time (req_heat_off_time),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_next_state    (rsp_next_state),
      .csr_write         (csr_write),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   // 2 ns period: low for 1 ns, high for 1 ns.
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Works out the next mode for one request and advances the remembered
   // conditioning function exactly as the block should. A pair with no rule
   // falls through to the illegal code; a failed guard holds the present mode.
   function automatic htms_pkg::mode_type predict_next_mode(input htms_pkg::req_type r);
      htms_pkg::mode_type nx;
      nx = htms_pkg::MODE_ILLEGAL;
      case (r.present_state)
         htms_pkg::MODE_OFF: begin
            case (r.wanted_state)
               htms_pkg::MODE_FAN, htms_pkg::MODE_COOL, htms_pkg::MODE_HEAT: begin
                  nx = (r.fan_off_time < model_cfg.fan_min_off) ? htms_pkg::MODE_OFF
                                                                : htms_pkg::MODE_FAN;
               end
               default: nx = htms_pkg::MODE_ILLEGAL;
            endcase
         end
         htms_pkg::MODE_FAN: begin
            case (r.wanted_state)
               htms_pkg::MODE_OFF: begin
                  nx = (r.fan_on_time < model_cfg.fan_min_on) ? htms_pkg::MODE_FAN
                                                              : htms_pkg::MODE_OFF;
               end
               htms_pkg::MODE_COOL: begin
                  // Cooling soon after either function needs the fan pre-run first.
                  if ((r.cool_off_time < htms_pkg::CoolInstantGapDefault ||
                       r.heat_off_time < htms_pkg::CoolInstantGapDefault) &&
                      r.fan_on_time < model_cfg.fan_before_cool) begin
                     nx = htms_pkg::MODE_FAN;
                  end else if (model_last_func != htms_pkg::LF_UNKNOWN &&
                               (r.cool_off_time < htms_pkg::CoolToCoolGapDefault ||
                                r.heat_off_time < htms_pkg::HeatToCoolGapDefault)) begin
                     nx = htms_pkg::MODE_FAN;
                  end else begin
                     model_last_func = htms_pkg::LF_COOL;
                     nx = htms_pkg::MODE_COOL;
                  end
               end
               htms_pkg::MODE_HEAT: begin
                  if ((r.heat_off_time < htms_pkg::HeatInstantGapDefault ||
                       r.cool_off_time < htms_pkg::HeatInstantGapDefault) &&
                      r.fan_on_time < model_cfg.fan_before_heat) begin
                     nx = htms_pkg::MODE_FAN;
                  end else if (model_last_func != htms_pkg::LF_UNKNOWN &&
                               (r.heat_off_time < htms_pkg::HeatToHeatGapDefault ||
                                r.cool_off_time < htms_pkg::CoolToHeatGapDefault)) begin
                     nx = htms_pkg::MODE_FAN;
                  end else begin
                     model_last_func = htms_pkg::LF_HEAT;
                     nx = htms_pkg::MODE_HEAT;
                  end
               end
               default: nx = htms_pkg::MODE_ILLEGAL;
            endcase
         end
         htms_pkg::MODE_COOL: begin
            case (r.wanted_state)
               htms_pkg::MODE_OFF, htms_pkg::MODE_FAN, htms_pkg::MODE_HEAT,
               htms_pkg::MODE_COOLFAN: begin
                  if (r.cool_on_time < model_cfg.cool_min_on) begin
                     nx = htms_pkg::MODE_COOL;
                  end else begin
                     model_last_func = htms_pkg::LF_COOL;
                     nx = htms_pkg::MODE_COOLFAN;
                  end
               end
               default: nx = htms_pkg::MODE_ILLEGAL;
            endcase
         end
         htms_pkg::MODE_HEAT: begin
            case (r.wanted_state)
               htms_pkg::MODE_OFF, htms_pkg::MODE_FAN, htms_pkg::MODE_COOL,
               htms_pkg::MODE_HEATFAN: begin
                  if (r.heat_on_time < model_cfg.heat_min_on) begin
                     nx = htms_pkg::MODE_HEAT;
                  end else begin
                     model_last_func = htms_pkg::LF_HEAT;
                     nx = htms_pkg::MODE_HEATFAN;
                  end
               end
               default: nx = htms_pkg::MODE_ILLEGAL;
            endcase
         end
         htms_pkg::MODE_COOLFAN: begin
            case (r.wanted_state)
               htms_pkg::MODE_OFF: begin
                  nx = (r.cool_off_time < model_cfg.fan_after_cool) ? htms_pkg::MODE_COOLFAN
                                                                    : htms_pkg::MODE_OFF;
               end
               htms_pkg::MODE_FAN, htms_pkg::MODE_COOL, htms_pkg::MODE_HEAT: begin
                  nx = (r.cool_off_time < model_cfg.fan_after_cool) ? htms_pkg::MODE_COOLFAN
                                                                    : htms_pkg::MODE_FAN;
               end
               default: nx = htms_pkg::MODE_ILLEGAL;
            endcase
         end
         htms_pkg::MODE_HEATFAN: begin
            case (r.wanted_state)
               htms_pkg::MODE_OFF: begin
                  nx = (r.heat_off_time < model_cfg.fan_after_heat) ? htms_pkg::MODE_HEATFAN
                                                                    : htms_pkg::MODE_OFF;
               end
               htms_pkg::MODE_FAN, htms_pkg::MODE_COOL, htms_pkg::MODE_HEAT: begin
                  nx = (r.heat_off_time < model_cfg.fan_after_heat) ? htms_pkg::MODE_HEATFAN
                                                                    : htms_pkg::MODE_FAN;
               end
               default: nx = htms_pkg::MODE_ILLEGAL;
            endcase
         end
         default: nx = htms_pkg::MODE_ILLEGAL;
      endcase
      return nx;
   endfunction

   // Gap before a beat: with a chance of pct percent a random nonzero gap, otherwise none.
   function automatic int draw_gap(input int pct);
      if (pct > 0 && $urandom_range(1, 100) <= pct) return $urandom_range(1, 16);
      return 0;
   endfunction

   // Timer values cluster around the threshold that matters and the fixed
   // 300-count gaps, with the field extremes and fully random values mixed in.
   function automatic time_type pick_time(input time_type near);
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return '1;
         2, 3:    return time_type'($urandom);
         4, 5:    return near + time_type'($urandom_range(0, 2)) - 1'b1;
         default: return htms_pkg::CoolInstantGapDefault +
                         time_type'($urandom_range(0, 2)) - 1'b1;
      endcase
   endfunction

   function automatic htms_pkg::req_type make_request(input htms_pkg::mode_type present,
                                                      input htms_pkg::mode_type wanted,
                                                      input int fon, input int foff,
                                                      input int con, input int coff,
                                                      input int hon, input int hoff);
      htms_pkg::req_type r;
      r.present_state = present;
      r.wanted_state  = wanted;
      r.fan_on_time   = time_type'(fon);
      r.fan_off_time  = time_type'(foff);
      r.cool_on_time  = time_type'(con);
      r.cool_off_time = time_type'(coff);
      r.heat_on_time  = time_type'(hon);
      r.heat_off_time = time_type'(hoff);
      return r;
   endfunction

   // Mostly a walk: the present mode is the one the block last decided on, so
   // cooling and heating cycles are actually reached. The rest are random
   // pairs, including the initial and illegal codes.
   function automatic htms_pkg::req_type random_request();
      htms_pkg::req_type r;
      int unsigned sel;
      sel = $urandom_range(0, 9);
      if (sel < 7 && last_prediction <= htms_pkg::MODE_HEATFAN) begin
         r.present_state = last_prediction;
      end else if (sel < 9) begin
         r.present_state = htms_pkg::mode_type'($urandom_range(0, 5));
      end else begin
         r.present_state = htms_pkg::mode_type'($urandom_range(0, 7));
      end
      r.wanted_state = ($urandom_range(0, 9) == 0) ? htms_pkg::mode_type'($urandom_range(0, 7))
                                                   : htms_pkg::mode_type'($urandom_range(0, 5));
      r.fan_on_time   = pick_time($urandom_range(0, 1) ? model_cfg.fan_min_on
                                                       : ($urandom_range(0, 1) ?
                                                          model_cfg.fan_before_cool :
                                                          model_cfg.fan_before_heat));
      r.fan_off_time  = pick_time(model_cfg.fan_min_off);
      r.cool_on_time  = pick_time(model_cfg.cool_min_on);
      r.cool_off_time = pick_time(model_cfg.fan_after_cool);
      r.heat_on_time  = pick_time(model_cfg.heat_min_on);
      r.heat_off_time = pick_time(model_cfg.fan_after_heat);
      return r;
   endfunction

   // Offers one request beat and returns once it has been taken. The expected
   // mode is worked out at the edge where the beat is accepted, so the
   // predictor sees requests in exactly the order the block does.
   task automatic send_request(input htms_pkg::req_type r);
      int gap;
      gap = draw_gap(req_gap_pct);
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid         <= 1'b1;
      req_present_state <= r.present_state;
      req_wanted_state  <= r.wanted_state;
      req_fan_on_time   <= r.fan_on_time;
      req_fan_off_time  <= r.fan_off_time;
      req_cool_on_time  <= r.cool_on_time;
      req_cool_off_time <= r.cool_off_time;
      req_heat_on_time  <= r.heat_on_time;
      req_heat_off_time <= r.heat_off_time;
      do @(posedge clock); while (req_stall);
      last_prediction = predict_next_mode(r);
      pending_modes.push_back(last_prediction);
   endtask

   // Drops valid and waits for every owed response, then lets the pipeline
   // settle so that nothing is left in it. Anything never delivered fails.
   task automatic wait_until_drained();
      int guard;
      guard = 0;
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_modes.size() != 0 && guard < 5000) begin
         @(posedge clock);
         guard++;
      end
      if (pending_modes.size() != 0) begin
         $error("%0d response beats never arrived", pending_modes.size());
         failures++;
         pending_modes.delete();
      end
      repeat (3) @(posedge clock);
   endtask

   // One register write; write enable is dropped on the following falling edge
   // so that back-to-back writes never lower and raise it in the same step.
   task automatic write_threshold(input htms_pkg::csr_index_type idx, input time_type value);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(negedge clock);
      csr_write <= 1'b0;
      case (idx)
         htms_pkg::CSR_FAN_MIN_OFF:     model_cfg.fan_min_off     = value;
         htms_pkg::CSR_FAN_MIN_ON:      model_cfg.fan_min_on      = value;
         htms_pkg::CSR_COOL_MIN_ON:     model_cfg.cool_min_on     = value;
         htms_pkg::CSR_HEAT_MIN_ON:     model_cfg.heat_min_on     = value;
         htms_pkg::CSR_FAN_AFTER_COOL:  model_cfg.fan_after_cool  = value;
         htms_pkg::CSR_FAN_AFTER_HEAT:  model_cfg.fan_after_heat  = value;
         htms_pkg::CSR_FAN_BEFORE_COOL: model_cfg.fan_before_cool = value;
         htms_pkg::CSR_FAN_BEFORE_HEAT: model_cfg.fan_before_heat = value;
         default: ;
      endcase
   endtask

   // Rewrites all eight thresholds with values drawn from [lo, hi], only once
   // the block has gone quiet.
   task automatic set_thresholds(input int unsigned lo, input int unsigned hi);
      wait_until_drained();
      for (int i = 0; i < 8; i++) begin
         write_threshold(htms_pkg::csr_index_type'(i), time_type'($urandom_range(lo, hi)));
      end
   endtask

   task automatic run_random_walk(input int count);
      for (int i = 0; i < count; i++) send_request(random_request());
   endtask

   // Every min-on, min-off and fan-after threshold on both sides, the fan pre-run
   // and the inter-function gaps before and after a function is known, unlisted and
   // illegal pairs, and all-zero and all-ones timers. Runs on reset values.
   task automatic test_mode_table_edges();
      req_gap_pct = 30;
      rsp_gap_pct = 30;
      send_request(make_request(htms_pkg::MODE_OFF, htms_pkg::MODE_FAN, 0, 59, 0, 0, 0, 0));
      send_request(make_request(htms_pkg::MODE_OFF, htms_pkg::MODE_COOL, 0, 60, 0, 0, 0, 0));
      send_request(make_request(htms_pkg::MODE_FAN, htms_pkg::MODE_OFF, 59, 0, 0, 0, 0, 0));
      send_request(make_request(htms_pkg::MODE_FAN, htms_pkg::MODE_OFF, 65535, 0, 0, 0,
                                0, 0));
      // Cooling wanted too soon after a stop, fan not yet pre-run.
      send_request(make_request(htms_pkg::MODE_FAN, htms_pkg::MODE_COOL, 29, 0, 0, 299,
                                0, 65535));
      // No function known yet, so the long gaps are waived once pre-run is met.
      send_request(make_request(htms_pkg::MODE_FAN, htms_pkg::MODE_HEAT, 30, 0, 0, 0, 0, 0));
      // Heating is now remembered: the heat-to-cool gap applies.
      send_request(make_request(htms_pkg::MODE_FAN, htms_pkg::MODE_COOL, 65535, 0, 0, 65535,
                                0, 299));
      send_request(make_request(htms_pkg::MODE_FAN, htms_pkg::MODE_COOL, 0, 0, 0, 300,
                                0, 300));
      send_request(make_request(htms_pkg::MODE_COOL, htms_pkg::MODE_HEAT, 0, 0, 179, 0,
                                0, 0));
      send_request(make_request(htms_pkg::MODE_COOL, htms_pkg::MODE_COOLFAN, 0, 0, 180, 0,
                                0, 0));
      send_request(make_request(htms_pkg::MODE_COOLFAN, htms_pkg::MODE_OFF, 0, 0, 0, 59,
                                0, 0));
      send_request(make_request(htms_pkg::MODE_COOLFAN, htms_pkg::MODE_HEAT, 0, 0, 0, 60,
                                0, 0));
      send_request(make_request(htms_pkg::MODE_HEAT, htms_pkg::MODE_OFF, 0, 0, 0, 0,
                                179, 0));
      send_request(make_request(htms_pkg::MODE_HEAT, htms_pkg::MODE_HEATFAN, 0, 0, 0, 0,
                                65535, 0));
      send_request(make_request(htms_pkg::MODE_HEATFAN, htms_pkg::MODE_COOL, 0, 0, 0, 0,
                                0, 59));
      send_request(make_request(htms_pkg::MODE_HEATFAN, htms_pkg::MODE_OFF, 0, 0, 0, 0,
                                0, 60));
      send_request(make_request(htms_pkg::MODE_FAN, htms_pkg::MODE_HEAT, 65535, 0, 0, 299,
                                0, 65535));
      // Pairs outside the table, the initial and illegal codes among them.
      send_request(make_request(htms_pkg::MODE_INITIAL, htms_pkg::MODE_OFF, 0, 0, 0, 0,
                                0, 0));
      send_request(make_request(htms_pkg::MODE_OFF, htms_pkg::MODE_INITIAL, 0, 0, 0, 0,
                                0, 0));
      send_request(make_request(htms_pkg::MODE_ILLEGAL, htms_pkg::MODE_ILLEGAL, 65535, 65535,
                                65535, 65535, 65535, 65535));
      send_request(make_request(htms_pkg::MODE_COOL, htms_pkg::MODE_COOL, 65535, 65535,
                                65535, 65535, 65535, 65535));
      send_request(make_request(htms_pkg::MODE_OFF, htms_pkg::MODE_OFF, 0, 0, 0, 0, 0, 0));
      send_request(make_request(htms_pkg::MODE_HEATFAN, htms_pkg::MODE_HEATFAN, 0, 0, 0, 0,
                                0, 0));
   endtask

   // A stretch with no idling on either side, then heavy idling.
   task automatic test_idling_mix();
      req_gap_pct = 0;
      rsp_gap_pct = 0;
      run_random_walk(60);
      req_gap_pct = 50;
      rsp_gap_pct = 50;
      run_random_walk(80);
   endtask

   // Thresholds at both extremes: all zero lets every guard pass but the fixed
   // inter-function gaps, all ones makes most guards hold.
   task automatic test_threshold_extremes();
      set_thresholds(0, 0);
      run_random_walk(60);
      set_thresholds(65535, 65535);
      run_random_walk(60);
   endtask

   task automatic test_random_thresholds();
      for (int i = 0; i < 3; i++) begin
         req_gap_pct = $urandom_range(0, 60);
         rsp_gap_pct = $urandom_range(0, 60);
         set_thresholds(0, 400);
         run_random_walk(50);
      end
      set_thresholds(0, 65535);
      run_random_walk(40);
   endtask

   // The receiver holds off for a long stretch while requests keep coming
   // back to back, so both internal registers fill and req_stall must rise.
   task automatic test_output_backpressure();
      req_gap_pct = 0;
      rsp_gap_pct = 10;
      hold_cycles = 64;
      run_random_walk(30);
   endtask

   // Receiver: after each response beat it draws how many cycles to stall
   // before taking the next one. A pending hold-off overrides everything.
   always @(negedge clock) begin
      if (beat_taken) begin
         beat_taken = 1'b0;
         stall_left = draw_gap(rsp_gap_pct);
      end
      if (hold_cycles > 0) begin
         rsp_stall <= 1'b1;
         hold_cycles--;
      end else if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Response checker: every accepted beat must match the oldest owed mode.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         beat_taken = 1'b1;
         if (pending_modes.size() == 0) begin
            $error("next_state: no response expected, got %0d", rsp_next_state);
            failures++;
         end else begin
            owed_mode = pending_modes.pop_front();
            if (rsp_next_state !== owed_mode) begin
               $error("next_state: expected %0d, got %0d", owed_mode, rsp_next_state);
               failures++;
            end
         end
      end
   end

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_mode_table_edges();
      test_idling_mix();
      test_threshold_extremes();
      test_random_thresholds();
      test_output_backpressure();

      wait_until_drained();
      if (failures == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest correct run.
   initial begin
      #400_000;
      $display("Test completed with failures");
      $finish;
   end

endmodule

`default_nettype wire

>>> hvac_timed_mode_sequencer.f
hdl/htms_pkg.sv
hdl/htms_csr.sv
hdl/htms_decide.sv
hdl/hvac_timed_mode_sequencer.sv
tb/tb.sv
